>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/tdpt_pkg.sv
// Package with the shared constants and types of the trial division prime test unit.
`default_nettype none

package tdpt_pkg;

    localparam int DEFAULT_WIDTH = 32;
    localparam int OUT_W         = 31;
    localparam int FIRST_CAND    = 3;
    localparam int FIRST_SQUARE  = 9;
    localparam int CAND_STEP     = 2;
    localparam int SQUARE_BIAS   = 4;

    typedef struct packed {
        logic init;
        logic step;
    } cand_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/trial_division_prime_test_unit.sv
// Top level of the trial division prime test unit: sequencer and result register.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------
//  in      | into unit | in_valid / in_stall  | number
//  out     | out of it | out_valid / out_stall| is_prime, divisor, quotient
//
// An even number goes from idle straight to the write state, with no division. An odd
// number is tried against odd candidates from 3 until the candidate squared exceeds
// it; each candidate passes through the check state and one bit-serial division.
// Reset is asynchronous and active low; it clears the sequencer and the output beat.
// One number is in work at a time; a new beat is taken while a result still waits.
`default_nettype none

`include "assert_macros.svh"

module trial_division_prime_test_unit #(
    parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [WIDTH-1:0]         number,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          is_prime,
    output logic [tdpt_pkg::OUT_W-1:0]    divisor,
    output logic [tdpt_pkg::OUT_W-1:0]    quotient
);

    localparam int OW    = tdpt_pkg::OUT_W;
    localparam int CW    = (WIDTH + 1) / 2 + 2;
    localparam int CEXT  = CW > OW ? CW : OW;
    localparam int QEXT  = WIDTH > OW ? WIDTH : OW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    state_t               state_reg;
    logic [WIDTH-1:0]     held_reg;
    logic                 res_prime_reg;
    logic [OW-1:0]        res_div_reg;
    logic [OW-1:0]        res_quo_reg;
    logic                 out_valid_reg;
    logic                 is_prime_reg;
    logic [OW-1:0]        divisor_reg;
    logic [OW-1:0]        quotient_reg;

    logic                 accept;
    logic                 out_free;
    tdpt_pkg::cand_ctrl_t cand_ctrl;
    logic [CW-1:0]        cand;
    logic                 past_root;
    logic                 div_start;
    logic                 div_done;
    logic [WIDTH-1:0]     div_quo;
    logic [CW-1:0]        div_rem;
    logic [CEXT-1:0]      cand_ext;
    logic [QEXT-1:0]      quo_ext;
    logic [QEXT-1:0]      half_ext;

    assign in_stall  = state_reg != ST_IDLE;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign div_start = (state_reg == ST_CHECK) && !past_root;

    assign cand_ctrl.init = accept && number[0];
    assign cand_ctrl.step = (state_reg == ST_DIVIDE) && div_done && (div_rem != '0);

    assign cand_ext = CEXT'(cand);
    assign quo_ext  = QEXT'(div_quo);
    assign half_ext = QEXT'(number >> 1);

    tdpt_cand #(
        .W(WIDTH)
    ) u_cand (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cand_ctrl),
        .number    (held_reg),
        .cand      (cand),
        .past_root (past_root)
    );

    tdpt_divider #(
        .DW(WIDTH),
        .VW(CW)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (held_reg),
        .divisor_in (cand),
        .done       (div_done),
        .quo        (div_quo),
        .rem        (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            res_prime_reg <= 1'b0;
            res_div_reg   <= '0;
            res_quo_reg   <= '0;
            out_valid_reg <= 1'b0;
            is_prime_reg  <= 1'b0;
            divisor_reg   <= '0;
            quotient_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_WRITE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        held_reg <= number;
                        if (number[0])
                        begin
                            state_reg <= ST_CHECK;
                        end
                        else
                        begin
                            // Two is the only even prime.
                            if (number == WIDTH'(2))
                            begin
                                res_prime_reg <= 1'b1;
                                res_div_reg   <= '0;
                                res_quo_reg   <= '0;
                            end
                            else
                            begin
                                res_prime_reg <= 1'b0;
                                res_div_reg   <= OW'(2);
                                res_quo_reg   <= half_ext[OW-1:0];
                            end
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_CHECK:
                begin
                    if (past_root)
                    begin
                        res_prime_reg <= 1'b1;
                        res_div_reg   <= '0;
                        res_quo_reg   <= '0;
                        state_reg     <= ST_WRITE;
                    end
                    else
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        if (div_rem == '0)
                        begin
                            res_prime_reg <= 1'b0;
                            res_div_reg   <= cand_ext[OW-1:0];
                            res_quo_reg   <= quo_ext[OW-1:0];
                            state_reg     <= ST_WRITE;
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        is_prime_reg  <= res_prime_reg;
                        divisor_reg   <= res_div_reg;
                        quotient_reg  <= res_quo_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;
    assign divisor   = divisor_reg;
    assign quotient  = quotient_reg;

    `TDPT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != ST_IDLE)
    `TDPT_ASSERT_SAME(a_done_only_in_divide, clk, rst_n, div_done, state_reg == ST_DIVIDE)
    `TDPT_ASSERT_SAME(a_composite_has_divisor, clk, rst_n, out_valid_reg && !is_prime_reg,
                      divisor_reg != '0)

endmodule

`default_nettype wire

>>> hw/rtl/tdpt_divider.sv
// Bit-serial restoring divider that yields one quotient bit per cycle.
`default_nettype none

module tdpt_divider #(
    parameter int DW = tdpt_pkg::DEFAULT_WIDTH,
    parameter int VW = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor_in,
    output logic               done,
    output logic [DW-1:0]      quo,
    output logic [VW-1:0]      rem
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [VW:0]      shifted;
    logic [VW:0]      diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, divisor_in};
    assign fits    = ~diff[VW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg <= dividend;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(DW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                rem_reg <= fits ? diff[VW-1:0] : shifted[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tdpt_cand.sv
// Odd candidate generator that tracks the square of the candidate incrementally.
`default_nettype none

module tdpt_cand #(
    parameter int W = tdpt_pkg::DEFAULT_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tdpt_pkg::cand_ctrl_t ctrl,
    input  wire logic [W-1:0]         number,
    output logic [(W+1)/2+1:0]        cand,
    output logic                      past_root
);

    localparam int CW  = (W + 1) / 2 + 2;
    localparam int SQW = W + 2;

    logic [CW-1:0]  cand_reg;
    logic [SQW-1:0] sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
            sq_reg   <= '0;
        end
        else if (ctrl.init)
        begin
            cand_reg <= CW'(tdpt_pkg::FIRST_CAND);
            sq_reg   <= SQW'(tdpt_pkg::FIRST_SQUARE);
        end
        else if (ctrl.step)
        begin
            // (c + 2)^2 = c^2 + 4c + 4
            cand_reg <= cand_reg + CW'(tdpt_pkg::CAND_STEP);
            sq_reg   <= sq_reg + SQW'({cand_reg, 2'b00}) + SQW'(tdpt_pkg::SQUARE_BIAS);
        end
    end

    assign cand      = cand_reg;
    assign past_root = sq_reg > {2'b00, number};

endmodule

`default_nettype wire

>>> sim/trial_division_prime_test_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the trial division prime test unit with random gaps and stalls.
module trial_division_prime_test_unit_tb;

    localparam int OUT_W        = tdpt_pkg::OUT_W;
    localparam int STALL_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 78;
    localparam int HOLD_AFTER   = 30;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [31:0] value;
        bit          drain_first;
    } queued_number_t;

    typedef struct {
        logic             is_prime;
        logic [OUT_W-1:0] divisor;
        logic [OUT_W-1:0] quotient;
    } verdict_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [31:0]      number    = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             is_prime;
    logic [OUT_W-1:0] divisor;
    logic [OUT_W-1:0] quotient;

    queued_number_t numbers_to_send[$];
    verdict_t       verdicts_due[$];
    queued_number_t next_beat;
    verdict_t       expected_verdict;

    int mismatches       = 0;
    int verdicts_checked = 0;
    int send_gap         = 0;
    int send_quiet       = 0;
    int stall_left       = 0;
    int hold_left        = 0;
    int recv_quiet       = 0;
    int idle_cycles      = 0;

    trial_division_prime_test_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .divisor   (divisor),
        .quotient  (quotient)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic verdict_t predict_verdict(input logic [31:0] value);
        longint unsigned n;
        longint unsigned half;
        longint unsigned c;
        bit              found;
        verdict_t        v;
        n          = value;
        v.is_prime = 1'b1;
        v.divisor  = '0;
        v.quotient = '0;
        found      = 1'b0;
        if (n % 2 == 0)
        begin
            if (n != 2)
            begin
                v.is_prime = 1'b0;
                v.divisor  = OUT_W'(2);
                v.quotient = OUT_W'(n / 2);
            end
        end
        else
        begin
            half = n / 2;
            c    = 3;
            while (!found && c < half && c * c <= n)
            begin
                if (n % c == 0)
                begin
                    found      = 1'b1;
                    v.is_prime = 1'b0;
                    v.divisor  = OUT_W'(c);
                    v.quotient = OUT_W'(n / c);
                end
                else
                begin
                    c = c + 2;
                end
            end
        end
        return v;
    endfunction

    function automatic int draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Odd numbers are built with a small odd factor or kept small, so that no
    // search runs long; a few come from the upper half of the 24-bit range.
    function automatic logic [31:0] pick_number();
        int unsigned     kind;
        int unsigned     f;
        longint unsigned m;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            return $urandom & 32'hFFFF_FFFE;
        if (kind < 65)
        begin
            f = 2 * $urandom_range(1, 30) + 1;
            m = $urandom_range(1, 32'hFFFF_FFFF / f);
            return 32'(f * m);
        end
        if (kind < 90)
            return $urandom_range(0, 32'h0000_FFFF);
        if (kind < 97)
            return $urandom_range(0, 32'h000F_FFFF);
        return $urandom_range(32'h0080_0000, 32'h00FF_FFFF) | 32'd1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("result %0d: %s", verdicts_checked, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            number   <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                verdicts_due.push_back(predict_verdict(number));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (numbers_to_send.size() != 0 &&
                         !(numbers_to_send[0].drain_first && verdicts_due.size() != 0))
                begin
                    next_beat = numbers_to_send.pop_front();
                    in_valid <= 1'b1;
                    number   <= next_beat.value;
                    if (send_quiet > 0)
                    begin
                        send_quiet--;
                    end
                    else
                    begin
                        send_gap = draw_gap();
                        if ($urandom_range(0, 15) == 0)
                            send_quiet = $urandom_range(10, 30);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch("result beat with no number outstanding");
                end
                else
                begin
                    expected_verdict = verdicts_due.pop_front();
                    if (is_prime !== expected_verdict.is_prime)
                        report_mismatch($sformatf("is_prime %b, expected %b",
                                                  is_prime, expected_verdict.is_prime));
                    if (divisor !== expected_verdict.divisor)
                        report_mismatch($sformatf("divisor %0d, expected %0d",
                                                  divisor, expected_verdict.divisor));
                    if (quotient !== expected_verdict.quotient)
                        report_mismatch($sformatf("quotient %0d, expected %0d",
                                                  quotient, expected_verdict.quotient));
                end
                verdicts_checked++;
                // The long hold-off lets the unit fill up and stall its input.
                if (verdicts_checked == HOLD_AFTER)
                begin
                    hold_left = HOLD_CYCLES;
                end
                else if (recv_quiet > 0)
                begin
                    recv_quiet--;
                end
                else
                begin
                    stall_left = draw_gap();
                    if ($urandom_range(0, 15) == 0)
                        recv_quiet = $urandom_range(10, 30);
                end
            end
            else if (stall_left == 0 && hold_left == 0 && recv_quiet == 0 &&
                     $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 4);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0]    directed[$];
        queued_number_t item;
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15,
                     32'd17, 32'd25, 32'd49, 32'd121, 32'd1000003, 32'd1022117,
                     32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
                     32'hAAAA_AAAB, 32'h5555_5555, 32'd16777213};
        foreach (directed[i])
        begin
            item.value       = directed[i];
            item.drain_first = 1'b0;
            numbers_to_send.push_back(item);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            item.value       = pick_number();
            item.drain_first = (i == 0 || i == RANDOM_ITEMS / 2);
            numbers_to_send.push_back(item);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_to_send.size() != 0 || in_valid)
            @(negedge clk);
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
